// ===== hw/rtl/pscl_pkg.sv =====
// package for the phase to sine/cosine converter: constants, rom word type
// and elaboration-time functions that build the quarter-wave table
// no dependencies
package pscl_pkg;

    localparam int unsigned FRAC_BITS_DEF = 20;
    localparam int unsigned PHASE_W       = 32;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned ROM_W         = 2 * VALUE_W;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [29:0]        OFF_MASK     = 30'h3FFF_FFFF;

    // pi/2 in q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] ROUND_Q31   = 64'h0000_0000_4000_0000;
    localparam logic [63:0] SAT_Q31     = 64'h0000_0000_7FFF_FFFF;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    // rom word: {entry i, entry i+1 minus entry i}
    typedef logic [ROM_W-1:0] t_rom_word;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // taylor term divisor (2n)(2n+1), one literal per step
    function automatic logic [63:0] div_term(input logic [63:0] t, input int unsigned n);
        logic [63:0] r;
        unique case (n)
            1:       r = t / 64'd6;
            2:       r = t / 64'd20;
            3:       r = t / 64'd42;
            4:       r = t / 64'd72;
            5:       r = t / 64'd110;
            6:       r = t / 64'd156;
            7:       r = t / 64'd210;
            8:       r = t / 64'd272;
            9:       r = t / 64'd342;
            10:      r = t / 64'd420;
            11:      r = t / 64'd506;
            12:      r = t / 64'd600;
            13:      r = t / 64'd702;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // round(sin(i*pi/2N) * 2^31) saturated, N = 2^log2n
    function automatic logic [VALUE_W-1:0] rom_entry(input int unsigned i,
                                                     input int unsigned log2n);
        logic [127:0] p;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        int unsigned  k;
        int unsigned  n;
        k    = (i > (1 << log2n)) ? (1 << log2n) : i;
        p    = {64'd0, HALF_PI_Q62} * {96'd0, k};
        p    = p >> log2n;
        x    = p[63:0];
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (n = 1; n <= 13; n++) begin
            term = div_term(mul_q62(term, x2), n);
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        sum = (sum + ROUND_Q31) >> 31;
        if (sum > SAT_Q31)
            sum = SAT_Q31;
        return sum[VALUE_W-1:0];
    endfunction

    function automatic t_rom_word rom_word(input int unsigned i, input int unsigned log2n);
        logic [VALUE_W-1:0] y0;
        logic [VALUE_W-1:0] y1;
        y0 = rom_entry(i, log2n);
        y1 = rom_entry(i + 1, log2n);
        return {y0, y1 - y0};
    endfunction

endpackage

// ===== hw/rtl/pscl_rom.sv =====
// quarter-wave sine table with registered read, contents built at elaboration
// depends on pscl_pkg
module pscl_rom #(
    parameter int unsigned FRAC_BITS = pscl_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [30-FRAC_BITS:0]    i_addr,
    output pscl_pkg::t_rom_word      o_data
);
    import pscl_pkg::*;

    localparam int unsigned LOG2N = 30 - FRAC_BITS;
    localparam int unsigned DEPTH = (1 << LOG2N) + 1;

    t_rom_word w_rom [DEPTH];
    t_rom_word r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_word
        localparam t_rom_word WORD = rom_word(g, LOG2N);
        assign w_rom[g] = WORD;
    end

    // address never exceeds the last entry
    always_ff @(posedge i_clk) begin
        if (i_en)
            r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/phase_sine_cosine_lut_interp.sv =====
// phase to q31 sine/cosine: quarter-wave table with rounded linear interpolation
// pipeline: 4 register stages, the valid bit passes r_v1, r_v2, r_v3 and r_v4 to o_valid
// throughput: one item per clock while i_stall is low, with one single-port table read per item
// each stage loads while empty or while the one after it moves, so bubbles fill
// reset (i_rst_n low, synchronous) clears all stage valid bits; data is kept
// depends on pscl_pkg and pscl_rom
module phase_sine_cosine_lut_interp #(
    parameter int unsigned FRAC_BITS = pscl_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_operation,
    input  logic [pscl_pkg::PHASE_W-1:0]  i_phase,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic signed [pscl_pkg::VALUE_W-1:0] o_value,
    input  logic                          i_stall
);
    import pscl_pkg::*;

    localparam int unsigned PROD_W = VALUE_W + FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

    // stage enables, back to front
    logic en1, en2, en3, en4;

    // stage 0: fold phase into the first quadrant
    logic [PHASE_W-1:0]   s0_phase;
    logic [1:0]           s0_quad;
    logic [29:0]          s0_off;
    logic [30:0]          s0_u;

    // stage 1: table word out of the rom register
    logic                  r_v1;
    logic                  r_neg1;
    logic [FRAC_BITS-1:0]  r_frac1;
    t_rom_word             w_word1;

    // stage 2: slope times fraction
    logic                  r_v2;
    logic                  r_neg2;
    logic [VALUE_W-1:0]    r_y0_2;
    logic [PROD_W-1:0]     r_prod2;
    logic [PROD_W-1:0]     n_prod2;

    // stage 3: interpolated magnitude
    logic                  r_v3;
    logic                  r_neg3;
    logic [VALUE_W-1:0]    r_mag3;
    logic [PROD_W-1:0]     n_round3;
    logic [VALUE_W-1:0]    n_mag3;

    // stage 4: signed output register
    logic                  r_v4;
    logic [VALUE_W-1:0]    r_value4;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    // cosine is sine a quarter turn on, wrapping mod 2^32
    assign s0_phase = (i_operation == OP_COSINE) ? (i_phase + QUARTER_TURN) : i_phase;
    assign s0_quad  = s0_phase[31:30];
    assign s0_off   = s0_phase[29:0] & OFF_MASK;
    // odd quadrants run backward down the table; u reaches 2^30 only here
    assign s0_u     = s0_quad[0] ? (31'(QUARTER_TURN) - {1'b0, s0_off}) : {1'b0, s0_off};

    pscl_rom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (en1),
        .i_addr (s0_u[30:FRAC_BITS]),
        .o_data (w_word1)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_neg1  <= s0_quad[1];
            r_frac1 <= s0_u[FRAC_BITS-1:0];
        end
    end

    // slope is never negative, the table rises over the quarter
    assign n_prod2 = PROD_W'(w_word1[VALUE_W-1:0]) * PROD_W'(r_frac1);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_neg2  <= r_neg1;
            r_y0_2  <= w_word1[ROM_W-1:VALUE_W];
            r_prod2 <= n_prod2;
        end
    end

    // round half up over the fraction bits
    assign n_round3 = (r_prod2 + HALF_LSB) >> FRAC_BITS;
    assign n_mag3   = r_y0_2 + n_round3[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_neg3 <= r_neg2;
            r_mag3 <= n_mag3;
        end
    end

    // lower half of the turn is negated
    always_ff @(posedge i_clk) begin
        if (en4)
            r_value4 <= r_neg3 ? (VALUE_W'(0) - r_mag3) : r_mag3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_value = signed'(r_value4);

endmodule
